### hdl/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types, constants and helpers of the first-fit arena allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

    localparam int MAX_ALLOCS   = 64;
    localparam int HEADER_BYTES = 32;
    localparam int ALIGN_BYTES  = 8;
    localparam int ARENA_BYTES  = 1048576;

    localparam int FW = 21;                        // field width
    localparam int WW = FW + 3;                    // internal arithmetic width
    localparam int AW = $clog2(MAX_ALLOCS);        // table address width
    localparam int CW = $clog2(MAX_ALLOCS + 1);    // entry count width
    localparam int EW = 3 * FW;                    // table word: used, size, start
    localparam int MAX_SHIFT = 20;

    localparam int IN_DW  = 48;
    localparam int OUT_DW = 112;

    typedef logic [FW-1:0] t_fld;
    typedef logic [WW-1:0] t_wide;
    typedef logic [CW-1:0] t_cnt;

    localparam logic [1:0] KIND_ALLOC   = 2'd0;
    localparam logic [1:0] KIND_FREE    = 2'd1;
    localparam logic [1:0] KIND_REALLOC = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_NULL    = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    localparam logic [1:0] OP_NONE     = 2'd0;
    localparam logic [1:0] OP_COMMIT   = 2'd1;
    localparam logic [1:0] OP_UNCOMMIT = 2'd2;

    localparam logic [1:0] CFG_ARENA = 2'd0;
    localparam logic [1:0] CFG_BEGIN = 2'd1;
    localparam logic [1:0] CFG_SHIFT = 2'd2;

    localparam t_wide HDR_W   = WW'(HEADER_BYTES);
    localparam t_wide ALIGN_M = WW'(ALIGN_BYTES - 1);

    typedef struct packed {
        t_wide a;          // block start (or end) to page
        logic  down;       // round a down instead of up
        t_wide lim;        // lower bound, rounded up
        t_wide e_raw;      // range end before rounding and clipping
        logic  has_next;
        t_fld  next;       // start of the following block
    } t_rng_req;

    typedef struct packed {
        t_wide rb;
        t_wide re;
        logic  empty;
    } t_rng_res;

    typedef struct packed {
        logic [1:0] status;
        t_fld       offset;
        logic [1:0] op;
        t_fld       rb;
        t_fld       re;
        t_fld       cfrom;
        t_fld       cbytes;
        logic       last;
    } t_result;

    function automatic t_wide need_bytes(input t_fld req);
        t_wide v;
        v = WW'(req) + HDR_W + ALIGN_M;
        // round down to the alignment: divide and multiply by a constant
        return t_wide'((v / ALIGN_BYTES) * ALIGN_BYTES);
    endfunction

    function automatic logic gap_fits(input t_wide lo, input t_wide hi, input t_wide need);
        return (hi > lo) && ((hi - lo) >= need);
    endfunction

    function automatic t_result mk_result(input logic [1:0] status, input t_fld offset,
                                          input logic [1:0] op, input t_rng_res rng,
                                          input t_fld cfrom, input t_fld cbytes,
                                          input logic last);
        t_result r;
        r.status = status;
        r.offset = offset;
        r.op     = rng.empty ? OP_NONE : op;
        r.rb     = rng.empty ? '0 : rng.rb[FW-1:0];
        r.re     = rng.empty ? '0 : rng.re[FW-1:0];
        r.cfrom  = cfrom;
        r.cbytes = cbytes;
        r.last   = last;
        return r;
    endfunction

    function automatic logic [OUT_DW-1:0] pack_result(input t_result r);
        return {(OUT_DW - 5*FW - 4)'(0),
                r.cbytes, r.cfrom, r.re, r.rb, r.op, r.offset, r.status};
    endfunction

endpackage

### hdl/ffa_ram.sv
// ----------------------------------------------------------------------------
// ffa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### hdl/ffa_range_unit.sv
// ----------------------------------------------------------------------------
// ffa_range_unit
// Page range calculator shared by alloc, grow and free.
// ----------------------------------------------------------------------------
module ffa_range_unit import ffa_pkg::*; (
    input  t_rng_req   i_req,
    input  logic [4:0] i_page_shift,
    input  t_fld       i_arena,
    output t_rng_res   o_res
);

    logic [4:0] shift;
    t_wide      pm;
    t_wide      b_base;
    t_wide      b_lim;
    t_wide      e_up;
    t_wide      e_arena;
    t_wide      e_next;
    t_wide      b;
    t_wide      e;

    always_comb begin
        shift   = (i_page_shift > 5'(MAX_SHIFT)) ? 5'(MAX_SHIFT) : i_page_shift;
        pm      = (t_wide'(1) << shift) - t_wide'(1);
        b_base  = i_req.down ? (i_req.a & ~pm) : ((i_req.a + pm) & ~pm);
        b_lim   = (i_req.lim + pm) & ~pm;
        b       = (b_lim > b_base) ? b_lim : b_base;
        e_up    = (i_req.e_raw + pm) & ~pm;
        e_arena = (e_up > WW'(i_arena)) ? WW'(i_arena) : e_up;
        e_next  = WW'(i_req.next) & ~pm;
        e       = (i_req.has_next && (e_next < e_arena)) ? e_next : e_arena;
        o_res.rb    = b;
        o_res.re    = e;
        o_res.empty = (e <= b);
    end

endmodule

### hdl/first_fit_arena_allocator_unit.sv
// ----------------------------------------------------------------------------
// first_fit_arena_allocator_unit
// First-fit, address-ordered block allocator over a byte arena.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel (tuser = kind, tdata = request bytes
// and block offset) and answers leave on m_axis, one or two items per
// request, tlast on the final one. Configuration registers are written on
// the cfg channel, which is always ready; write them only while idle.
// The block table lives in a 64-entry RAM; one sequencer walks it with a
// read state and a check state per entry for the first-fit search and
// block lookup, and a read state and a write state per entry moved when a
// block is inserted or removed. s_axis_tready is high only while idle. A
// result holds on m_axis until taken; the sequencer waits meanwhile. Reset
// empties the table and loads the default arena size, data start and page
// shift.
// ----------------------------------------------------------------------------
module first_fit_arena_allocator_unit import ffa_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [IN_DW-1:0]  s_axis_tdata,   // request_bytes, block_offset, zero pad
    input  logic [1:0]        s_axis_tuser,   // kind
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_DW-1:0] m_axis_tdata,   // status, result_offset, range_op,
                                              // range_begin, range_end, copy_from,
                                              // copy_bytes, zero pad
    output logic              m_axis_tlast,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [FW-1:0]     i_cfg_data
);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_SRCH_RD  = 5'd1;
    localparam logic [4:0] S_SRCH_CHK = 5'd2;
    localparam logic [4:0] S_A_RANGE  = 5'd3;
    localparam logic [4:0] S_INS_RD   = 5'd4;
    localparam logic [4:0] S_INS_WR   = 5'd5;
    localparam logic [4:0] S_INS_NEW  = 5'd6;
    localparam logic [4:0] S_FIND_RD  = 5'd7;
    localparam logic [4:0] S_FIND_CHK = 5'd8;
    localparam logic [4:0] S_NEXT_RD  = 5'd9;
    localparam logic [4:0] S_NEXT_CHK = 5'd10;
    localparam logic [4:0] S_DISP     = 5'd11;
    localparam logic [4:0] S_FREE_RNG = 5'd12;
    localparam logic [4:0] S_DEL_RD   = 5'd13;
    localparam logic [4:0] S_DEL_WR   = 5'd14;
    localparam logic [4:0] S_EMIT_A   = 5'd15;
    localparam logic [4:0] S_EMIT_B   = 5'd16;

    localparam t_rng_res NO_RANGE = '{rb: '0, re: '0, empty: 1'b1};

    logic [4:0] r_state;
    t_fld       r_arena;
    t_fld       r_begin;
    logic [4:0] r_shift;
    t_cnt       r_cnt;
    t_cnt       r_k;
    t_cnt       r_pos;
    t_cnt       r_idx;
    logic       r_mv;
    logic [1:0] r_kind;
    t_fld       r_req;
    t_fld       r_blk;
    t_wide      r_need;
    t_wide      r_lo;
    t_fld       r_next;
    logic       r_has_next;
    t_fld       r_s;
    t_fld       r_z;
    t_fld       r_u;
    t_rng_res   r_rng;
    t_result    r_res_a;
    t_result    r_res;

    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [EW-1:0]  ram_wdata;
    logic [AW-1:0]  ram_raddr;
    logic [EW-1:0]  ram_rdata;
    t_fld           e_start;
    t_fld           e_size;
    t_fld           e_used;
    t_rng_req       rng_req;
    t_rng_res       rng_res;
    t_fld           in_req;
    t_fld           in_blk;
    t_wide          s_w;
    t_wide          z_w;
    t_wide          end_w;
    t_wide          hi_w;
    t_wide          gl_w;
    logic           shrink_ok;
    logic           grow_ok;
    logic           end_fit;
    t_fld           new_off;

    assign e_start = ram_rdata[FW-1:0];
    assign e_size  = ram_rdata[2*FW-1:FW];
    assign e_used  = ram_rdata[3*FW-1:2*FW];
    assign in_req  = s_axis_tdata[FW-1:0];
    assign in_blk  = s_axis_tdata[2*FW-1:FW];

    assign s_w       = WW'(r_s);
    assign z_w       = WW'(r_z);
    assign end_w     = s_w + z_w;
    assign hi_w      = r_has_next ? WW'(r_next) : WW'(r_arena);
    assign gl_w      = (hi_w > end_w) ? (hi_w - end_w) : '0;
    assign shrink_ok = (r_need <= z_w);
    assign grow_ok   = (r_need <= z_w + gl_w);
    assign end_fit   = gap_fits(r_lo, WW'(r_arena), r_need);
    assign new_off   = FW'(r_lo + HDR_W);

    ffa_ram #(.WIDTH(EW), .DEPTH(MAX_ALLOCS)) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    ffa_range_unit u_range (
        .i_req        (rng_req),
        .i_page_shift (r_shift),
        .i_arena      (r_arena),
        .o_res        (rng_res)
    );

    // operand select for the shared range unit
    always_comb begin
        rng_req.has_next = r_has_next;
        rng_req.next     = r_next;
        rng_req.down     = 1'b0;
        rng_req.lim      = '0;
        case (r_state)
            S_A_RANGE: begin
                rng_req.a     = r_lo;
                rng_req.e_raw = r_lo + r_need;
            end
            S_FREE_RNG: begin
                rng_req.a     = s_w;
                rng_req.down  = 1'b1;
                rng_req.lim   = r_lo;
                rng_req.e_raw = end_w;
            end
            default: begin
                rng_req.a     = end_w;
                rng_req.e_raw = s_w + r_need;
            end
        endcase
    end

    // table port control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_k[AW-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = r_k[AW-1:0];
        unique case (r_state)
            S_INS_RD:  ram_raddr = AW'(r_k - t_cnt'(1));
            S_INS_WR:  ram_we = 1'b1;
            S_INS_NEW: begin
                ram_we    = 1'b1;
                ram_waddr = r_pos[AW-1:0];
                ram_wdata = {r_req, r_need[FW-1:0], r_lo[FW-1:0]};
            end
            S_NEXT_RD: ram_raddr = AW'(r_idx + t_cnt'(1));
            S_DISP: begin
                ram_waddr = r_idx[AW-1:0];
                ram_we    = !(r_kind == KIND_FREE || r_mv) && grow_ok;
                ram_wdata = {r_req, shrink_ok ? r_z : r_need[FW-1:0], r_s};
            end
            S_DEL_RD:  ram_raddr = AW'(r_k + t_cnt'(1));
            S_DEL_WR:  ram_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_mv    <= 1'b0;
            r_arena <= FW'(ARENA_BYTES);
            r_begin <= FW'(4096);
            r_shift <= 5'd12;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_ARENA: r_arena <= i_cfg_data;
                    CFG_BEGIN: r_begin <= i_cfg_data;
                    CFG_SHIFT: r_shift <= i_cfg_data[4:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_kind <= s_axis_tuser;
                        r_req  <= in_req;
                        r_blk  <= in_blk;
                        r_need <= need_bytes(in_req);
                        r_mv   <= 1'b0;
                        r_k    <= '0;
                        r_lo   <= WW'(r_begin);
                        if (s_axis_tuser == KIND_ALLOC ||
                            (s_axis_tuser == KIND_REALLOC && in_blk == '0)) begin
                            if (in_req == '0) begin
                                r_res   <= mk_result(ST_NULL, '0, OP_NONE, NO_RANGE,
                                                     '0, '0, 1'b1);
                                r_state <= S_EMIT_B;
                            end else if (r_cnt >= t_cnt'(MAX_ALLOCS)) begin
                                r_res   <= mk_result(ST_NOSPACE, '0, OP_NONE, NO_RANGE,
                                                     '0, '0, 1'b1);
                                r_state <= S_EMIT_B;
                            end else begin
                                r_state <= S_SRCH_RD;
                            end
                        end else if (s_axis_tuser == KIND_FREE) begin
                            if (in_blk == '0) begin
                                r_res   <= mk_result(ST_NULL, '0, OP_NONE, NO_RANGE,
                                                     '0, '0, 1'b1);
                                r_state <= S_EMIT_B;
                            end else begin
                                r_state <= S_FIND_RD;
                            end
                        end else if (s_axis_tuser == KIND_REALLOC) begin
                            r_state <= S_FIND_RD;
                        end
                    end
                end
                S_SRCH_RD: begin
                    if (r_k == r_cnt) begin
                        r_has_next <= 1'b0;
                        r_pos      <= r_cnt;
                        if (end_fit) begin
                            r_state <= S_A_RANGE;
                        end else begin
                            r_res   <= mk_result(ST_NOSPACE, '0, OP_NONE, NO_RANGE,
                                                 '0, '0, 1'b1);
                            r_state <= S_EMIT_B;
                        end
                    end else begin
                        r_state <= S_SRCH_CHK;
                    end
                end
                S_SRCH_CHK: begin
                    if (gap_fits(r_lo, WW'(e_start), r_need)) begin
                        r_has_next <= 1'b1;
                        r_next     <= e_start;
                        r_pos      <= r_k;
                        r_state    <= S_A_RANGE;
                    end else begin
                        r_lo    <= WW'(e_start) + WW'(e_size);
                        r_k     <= r_k + t_cnt'(1);
                        r_state <= S_SRCH_RD;
                    end
                end
                S_A_RANGE: begin
                    r_rng   <= rng_res;
                    r_k     <= r_cnt;
                    r_state <= S_INS_RD;
                end
                S_INS_RD: begin
                    r_state <= (r_k == r_pos) ? S_INS_NEW : S_INS_WR;
                end
                S_INS_WR: begin
                    r_k     <= r_k - t_cnt'(1);
                    r_state <= S_INS_RD;
                end
                S_INS_NEW: begin
                    r_cnt <= r_cnt + t_cnt'(1);
                    if (r_mv) begin
                        // hold the alloc answer and go free the old block
                        r_res_a <= mk_result(ST_OK, new_off, OP_COMMIT, r_rng,
                                             r_blk, r_u, 1'b0);
                        r_k     <= '0;
                        r_lo    <= WW'(r_begin);
                        r_state <= S_FIND_RD;
                    end else begin
                        r_res   <= mk_result(ST_OK, new_off, OP_COMMIT, r_rng,
                                             '0, '0, 1'b1);
                        r_state <= S_EMIT_B;
                    end
                end
                S_FIND_RD: begin
                    if (r_k == r_cnt) begin
                        r_res   <= mk_result(ST_UNKNOWN, '0, OP_NONE, NO_RANGE,
                                             '0, '0, 1'b1);
                        r_state <= S_EMIT_B;
                    end else begin
                        r_state <= S_FIND_CHK;
                    end
                end
                S_FIND_CHK: begin
                    if (WW'(e_start) + HDR_W == WW'(r_blk)) begin
                        r_idx   <= r_k;
                        r_s     <= e_start;
                        r_z     <= e_size;
                        r_u     <= e_used;
                        r_state <= S_NEXT_RD;
                    end else begin
                        r_lo    <= WW'(e_start) + WW'(e_size);
                        r_k     <= r_k + t_cnt'(1);
                        r_state <= S_FIND_RD;
                    end
                end
                S_NEXT_RD: begin
                    if (r_idx + t_cnt'(1) < r_cnt) begin
                        r_state <= S_NEXT_CHK;
                    end else begin
                        r_has_next <= 1'b0;
                        r_state    <= S_DISP;
                    end
                end
                S_NEXT_CHK: begin
                    r_has_next <= 1'b1;
                    r_next     <= e_start;
                    r_state    <= S_DISP;
                end
                S_DISP: begin
                    if (r_kind == KIND_FREE || r_mv) begin
                        r_state <= S_FREE_RNG;
                    end else if (shrink_ok) begin
                        r_res   <= mk_result(ST_OK, r_blk, OP_NONE, NO_RANGE,
                                             '0, '0, 1'b1);
                        r_state <= S_EMIT_B;
                    end else if (grow_ok) begin
                        r_res   <= mk_result(ST_OK, r_blk, OP_COMMIT, rng_res,
                                             '0, '0, 1'b1);
                        r_state <= S_EMIT_B;
                    end else if (r_cnt >= t_cnt'(MAX_ALLOCS)) begin
                        r_res   <= mk_result(ST_NOSPACE, '0, OP_NONE, NO_RANGE,
                                             '0, '0, 1'b1);
                        r_state <= S_EMIT_B;
                    end else begin
                        r_mv    <= 1'b1;
                        r_k     <= '0;
                        r_lo    <= WW'(r_begin);
                        r_state <= S_SRCH_RD;
                    end
                end
                S_FREE_RNG: begin
                    // a move reports its new offset on the free item as well
                    r_res   <= mk_result(ST_OK, r_mv ? r_res_a.offset : t_fld'(0),
                                         OP_UNCOMMIT, rng_res, '0, '0, 1'b1);
                    r_k     <= r_idx;
                    r_state <= S_DEL_RD;
                end
                S_DEL_RD: begin
                    if (r_k + t_cnt'(1) == r_cnt) begin
                        r_cnt   <= r_cnt - t_cnt'(1);
                        r_state <= r_mv ? S_EMIT_A : S_EMIT_B;
                    end else begin
                        r_state <= S_DEL_WR;
                    end
                end
                S_DEL_WR: begin
                    r_k     <= r_k + t_cnt'(1);
                    r_state <= S_DEL_RD;
                end
                S_EMIT_A: begin
                    if (m_axis_tready) begin
                        r_state <= S_EMIT_B;
                    end
                end
                S_EMIT_B: begin
                    if (m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = (r_state == S_EMIT_A) || (r_state == S_EMIT_B);
    assign m_axis_tdata  = (r_state == S_EMIT_A) ? pack_result(r_res_a) : pack_result(r_res);
    assign m_axis_tlast  = (r_state == S_EMIT_A) ? r_res_a.last : r_res.last;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= t_cnt'(MAX_ALLOCS))
        else $error("block count above table depth");

    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_cnt) |-> (r_cnt == $past(r_cnt) + t_cnt'(1) ||
                             r_cnt == $past(r_cnt) - t_cnt'(1)))
        else $error("block count moved by more than one");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input accepted while a result is pending");

    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
            (m_axis_tvalid && m_axis_tlast))
        else $error("move result not followed by its free result");

endmodule
